### rtl/quadruped_gait_phase_sequencer_unit_defines.svh
// Assertion macros for the gait phase sequencer; clocked on clk, held off in reset.
`ifndef QUADRUPED_GAIT_PHASE_SEQUENCER_UNIT_DEFINES_SVH
`define QUADRUPED_GAIT_PHASE_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication
`define QGPS_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("gait sequencer check failed");

// next-cycle implication
`define QGPS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("gait sequencer check failed");

`endif

### rtl/qgps_pkg.sv
// Shared constants, types and tables of the gait phase sequencer.
package qgps_pkg;

  localparam int unsigned CYCLE_PERIOD_MS = 800;

  localparam int unsigned DT_W    = 12;
  localparam int unsigned WHEEL_W = 8;
  localparam int unsigned CMD_W   = 16;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned LEG_W   = 2;
  localparam int unsigned PHASE_W = 2;
  localparam int unsigned PAT_W   = 2;
  localparam int unsigned JNT_W   = 2;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  localparam int unsigned LEG_TOTAL = 4;
  localparam logic [LEG_W-1:0] LEG_LAST = LEG_W'(LEG_TOTAL - 1);

  // floor(dt*256/period) as a multiply by a rounded-up reciprocal; the shift is
  // large enough that the error stays below 1/period for every 20-bit dividend
  localparam int unsigned SCALED_W  = DT_W + WHEEL_W;
  localparam int unsigned DIV_SHIFT = 36;
  localparam longint unsigned DIV_RECIP =
    ((64'd1 << DIV_SHIFT) + CYCLE_PERIOD_MS - 1) / CYCLE_PERIOD_MS;
  localparam int unsigned RECIP_W = $clog2(DIV_RECIP + 1);
  localparam int unsigned PROD_W  = SCALED_W + RECIP_W;
  localparam longint unsigned INC_MAX =
    (((64'd1 << DT_W) - 1) << WHEEL_W) / CYCLE_PERIOD_MS;
  localparam int unsigned INC_W = (INC_MAX < 2) ? 1 : $clog2(INC_MAX + 1);
  localparam int unsigned CMP_W = (INC_W > WHEEL_W) ? INC_W : WHEEL_W;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_GAIT_PATTERN = 2'd0;
  localparam logic [1:0] REG_LIMIT_HIGH   = 2'd1;
  localparam logic [1:0] REG_LIMIT_LOW    = 2'd2;

  localparam logic [PAT_W-1:0] PAT_STAND  = 2'd0;
  localparam logic [PAT_W-1:0] PAT_TROT   = 2'd1;
  localparam logic [PAT_W-1:0] PAT_BOUND  = 2'd2;
  localparam logic [PAT_W-1:0] PAT_GALLOP = 2'd3;

  localparam logic [JNT_W-1:0] JNT_HIP_YAW   = 2'd0;
  localparam logic [JNT_W-1:0] JNT_HIP_PITCH = 2'd1;
  localparam logic [JNT_W-1:0] JNT_KNEE      = 2'd2;

  localparam logic [MODE_W-1:0] MODE_BOOT     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CALIB    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_STAND    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LOCOMOTE = 3'd3;

  localparam logic signed [CMD_W-1:0] LIMIT_HIGH_RST = 16'sh7FFF;
  localparam logic signed [CMD_W-1:0] LIMIT_LOW_RST  = 16'sh8000;

  // fault and shutdown are never entered from here
  typedef enum logic [3:0] {
    ST_BOOT  = 4'b0001,
    ST_CALIB = 4'b0010,
    ST_STAND = 4'b0100,
    ST_LOCO  = 4'b1000
  } mode_state_t;

  typedef struct packed {
    logic [PAT_W-1:0]        gait_pattern;
    logic signed [CMD_W-1:0] limit_high;
    logic signed [CMD_W-1:0] limit_low;
  } cfg_t;

  typedef struct packed {
    logic [WHEEL_W-1:0] wheel;
    logic [MODE_W-1:0]  mode;
    logic [CNT_W-1:0]   cycles;
  } tick_t;

  function automatic logic [MODE_W-1:0] mode_code(input mode_state_t st);
    logic [MODE_W-1:0] code;
    case (st)
      ST_BOOT:  code = MODE_BOOT;
      ST_CALIB: code = MODE_CALIB;
      ST_STAND: code = MODE_STAND;
      ST_LOCO:  code = MODE_LOCOMOTE;
      default:  code = MODE_BOOT;
    endcase
    return code;
  endfunction

  function automatic logic [WHEEL_W-1:0] leg_offset(input logic [PAT_W-1:0] pat,
                                                     input logic [LEG_W-1:0] leg);
    logic [WHEEL_W-1:0] off;
    off = '0;
    case (pat)
      PAT_TROT:   off = (leg == 2'd1 || leg == 2'd2) ? 8'd128 : 8'd0;
      PAT_BOUND:  off = (leg == 2'd2 || leg == 2'd3) ? 8'd128 : 8'd0;
      PAT_GALLOP: begin
        case (leg)
          2'd1:    off = 8'd64;
          2'd2:    off = 8'd192;
          2'd3:    off = 8'd128;
          default: off = 8'd0;
        endcase
      end
      default:    off = 8'd0;
    endcase
    return off;
  endfunction

  // neutral-relative command of one joint in one phase, before mirror and clamp
  function automatic logic signed [CMD_W-1:0] joint_base(input logic [PHASE_W-1:0] ph,
                                                         input logic [JNT_W-1:0] jnt);
    logic signed [CMD_W-1:0] v;
    v = '0;
    case (jnt)
      JNT_HIP_PITCH: begin
        case (ph)
          2'd0:    v = -16'sd2000;
          2'd1:    v = 16'sd2500;
          2'd2:    v = -16'sd3500;
          default: v = 16'sd1000;
        endcase
      end
      JNT_KNEE: begin
        case (ph)
          2'd0:    v = -16'sd3000;
          2'd1:    v = 16'sd4000;
          2'd2:    v = -16'sd1500;
          default: v = -16'sd1000;
        endcase
      end
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/qgps_if.sv
// Tick input and leg result channel interfaces.
interface qgps_in_if;
  import qgps_pkg::*;
  logic            valid;
  logic            ready;
  logic [DT_W-1:0] dt_ms;
  modport source (output valid, output dt_ms, input ready);
  modport sink   (input valid, input dt_ms, output ready);
endinterface

interface qgps_out_if;
  import qgps_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [LEG_W-1:0]        leg_number;
  logic [PHASE_W-1:0]      leg_phase;
  logic signed [CMD_W-1:0] hip_yaw_cmd;
  logic signed [CMD_W-1:0] hip_pitch_cmd;
  logic signed [CMD_W-1:0] knee_cmd;
  logic [MODE_W-1:0]       mode_now;
  logic [CNT_W-1:0]        cycles_done;
  logic                    last_leg;
  modport source (output valid, output leg_number, output leg_phase, output hip_yaw_cmd,
                  output hip_pitch_cmd, output knee_cmd, output mode_now,
                  output cycles_done, output last_leg, input ready);
  modport sink   (input valid, input leg_number, input leg_phase, input hip_yaw_cmd,
                  input hip_pitch_cmd, input knee_cmd, input mode_now,
                  input cycles_done, input last_leg, output ready);
endinterface

### rtl/qgps_cfg.sv
// APB register bank: gait pattern and servo clamp limits.
module qgps_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [qgps_pkg::ADDR_W-1:0] paddr,
  input  logic [qgps_pkg::DATA_W-1:0] pwdata,
  output logic [qgps_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output qgps_pkg::cfg_t              cfg
);
  import qgps_pkg::*;

  logic [PAT_W-1:0]        gait_pattern_r;
  logic signed [CMD_W-1:0] limit_high_r;
  logic signed [CMD_W-1:0] limit_low_r;
  logic                    wr_en;
  logic [1:0]              reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gait_pattern_r <= PAT_STAND;
      limit_high_r   <= LIMIT_HIGH_RST;
      limit_low_r    <= LIMIT_LOW_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_GAIT_PATTERN: gait_pattern_r <= pwdata[PAT_W-1:0];
        REG_LIMIT_HIGH:   limit_high_r   <= pwdata[CMD_W-1:0];
        REG_LIMIT_LOW:    limit_low_r    <= pwdata[CMD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GAIT_PATTERN: prdata = DATA_W'(gait_pattern_r);
      REG_LIMIT_HIGH:   prdata = DATA_W'(limit_high_r);
      REG_LIMIT_LOW:    prdata = DATA_W'(limit_low_r);
      default:          prdata = '0;
    endcase
  end

  assign cfg.gait_pattern = gait_pattern_r;
  assign cfg.limit_high   = limit_high_r;
  assign cfg.limit_low    = limit_low_r;

endmodule

### rtl/qgps_tick.sv
// Tick stage: input register, gait wheel, cycle counter and mode machine.
module qgps_tick (
  input  logic           clk,
  input  logic           rst_n,
  input  qgps_pkg::cfg_t cfg,
  qgps_in_if.sink        in_ch,
  input  logic           take,
  output logic           tick_valid,
  output qgps_pkg::tick_t tick
);
  import qgps_pkg::*;

  logic               dt_valid_r;
  logic [DT_W-1:0]    dt_r;
  logic [WHEEL_W-1:0] wheel_r, wheel_nxt;
  logic [CNT_W-1:0]   cycles_r, cycles_nxt;
  mode_state_t        mode_r, mode_nxt;
  logic [PROD_W-1:0]  prod;
  logic [INC_W-1:0]   inc;
  logic               moving;
  logic               wrapped;
  logic               fire;

  assign in_ch.ready = !dt_valid_r || take;
  assign fire        = dt_valid_r && take;
  assign tick_valid  = dt_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      dt_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      dt_r <= in_ch.dt_ms;
    end
  end

  assign prod   = (PROD_W'(dt_r) << WHEEL_W) * PROD_W'(DIV_RECIP);
  assign inc    = prod[DIV_SHIFT +: INC_W];
  assign moving = (cfg.gait_pattern != PAT_STAND);

  always_comb begin
    wheel_nxt = '0;
    wrapped   = 1'b0;
    if (moving) begin
      wheel_nxt = wheel_r + WHEEL_W'(inc);
      // a wrap shows as the new position landing below the step
      wrapped   = (inc != '0) && (CMP_W'(wheel_nxt) < CMP_W'(inc));
    end
    cycles_nxt = cycles_r + CNT_W'(wrapped);
  end

  always_comb begin
    case (mode_r)
      ST_BOOT:  mode_nxt = ST_CALIB;
      ST_CALIB: mode_nxt = ST_STAND;
      ST_STAND: mode_nxt = moving ? ST_LOCO : ST_STAND;
      ST_LOCO:  mode_nxt = moving ? ST_LOCO : ST_STAND;
      default:  mode_nxt = ST_BOOT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_r  <= '0;
      cycles_r <= '0;
      mode_r   <= ST_BOOT;
    end else if (fire) begin
      wheel_r  <= wheel_nxt;
      cycles_r <= cycles_nxt;
      mode_r   <= mode_nxt;
    end
  end

  assign tick.wheel  = wheel_nxt;
  assign tick.mode   = mode_code(mode_nxt);
  assign tick.cycles = cycles_nxt;

endmodule

### rtl/qgps_legs.sv
// Leg stage: walks the four legs of a tick into the result register.
module qgps_legs (
  input  logic            clk,
  input  logic            rst_n,
  input  qgps_pkg::cfg_t  cfg,
  input  logic            tick_valid,
  input  qgps_pkg::tick_t tick,
  output logic            take,
  qgps_out_if.source      out_ch
);
  import qgps_pkg::*;

  logic                    word_valid_r;
  tick_t                   word_r;
  logic [LEG_W-1:0]        leg_r;
  logic                    out_valid_r;
  logic [LEG_W-1:0]        leg_number_r;
  logic [PHASE_W-1:0]      leg_phase_r;
  logic signed [CMD_W-1:0] hip_yaw_r, hip_pitch_r, knee_r;
  logic [MODE_W-1:0]       mode_r;
  logic [CNT_W-1:0]        cycles_r;
  logic                    last_leg_r;
  logic                    out_load;
  logic                    last;
  logic [WHEEL_W-1:0]      pos;
  logic [PHASE_W-1:0]      phase;
  logic                    right_side;

  function automatic logic signed [CMD_W-1:0] shape(input logic signed [CMD_W-1:0] base,
                                                    input logic mirror,
                                                    input logic signed [CMD_W-1:0] hi,
                                                    input logic signed [CMD_W-1:0] lo);
    logic signed [CMD_W-1:0] v;
    v = mirror ? -base : base;
    // upper clamp first, so a crossed pair leaves the lower limit
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v;
  endfunction

  assign out_load   = word_valid_r && (!out_valid_r || out_ch.ready);
  assign last       = (leg_r == LEG_LAST);
  assign take       = !word_valid_r || (out_load && last);
  assign pos        = word_r.wheel + leg_offset(cfg.gait_pattern, leg_r);
  assign phase      = pos[WHEEL_W-1 -: PHASE_W];
  assign right_side = leg_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_valid_r <= 1'b0;
      leg_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (take) begin
        word_valid_r <= tick_valid;
        leg_r        <= '0;
      end else if (out_load) begin
        leg_r <= leg_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && tick_valid) begin
      word_r <= tick;
    end
    if (out_load) begin
      leg_number_r <= leg_r;
      leg_phase_r  <= phase;
      hip_yaw_r    <= shape(joint_base(phase, JNT_HIP_YAW), right_side,
                            cfg.limit_high, cfg.limit_low);
      hip_pitch_r  <= shape(joint_base(phase, JNT_HIP_PITCH), right_side,
                            cfg.limit_high, cfg.limit_low);
      knee_r       <= shape(joint_base(phase, JNT_KNEE), right_side,
                            cfg.limit_high, cfg.limit_low);
      mode_r       <= word_r.mode;
      cycles_r     <= word_r.cycles;
      last_leg_r   <= last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.leg_number    = leg_number_r;
  assign out_ch.leg_phase     = leg_phase_r;
  assign out_ch.hip_yaw_cmd   = hip_yaw_r;
  assign out_ch.hip_pitch_cmd = hip_pitch_r;
  assign out_ch.knee_cmd      = knee_r;
  assign out_ch.mode_now      = mode_r;
  assign out_ch.cycles_done   = cycles_r;
  assign out_ch.last_leg      = last_leg_r;

endmodule

### rtl/quadruped_gait_phase_sequencer_unit.sv
// Top level of the quadruped gait phase sequencer.
//
// Each tick word (dt_ms) yields four leg words, front left to rear right, one per
// cycle from the single leg result register while out_ch.ready stays high; the legs
// of a tick already waiting follow without a gap. The first leg word of a tick goes
// through the input register, word_r and the leg result register. A further tick
// is taken into the input register while the legs of the previous one drain, and the
// wheel, cycle counter and mode step when it moves on to the leg stage. Write the
// registers only while no tick is in flight; there is no clearing pass after reset.
`include "quadruped_gait_phase_sequencer_unit_defines.svh"

module quadruped_gait_phase_sequencer_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  qgps_in_if.sink                     in_ch,
  qgps_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [qgps_pkg::ADDR_W-1:0] paddr,
  input  logic [qgps_pkg::DATA_W-1:0] pwdata,
  output logic [qgps_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import qgps_pkg::*;

  cfg_t  cfg;
  tick_t tick;
  logic  tick_valid;
  logic  tick_take;

  qgps_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  qgps_tick u_tick (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_ch      (in_ch),
    .take       (tick_take),
    .tick_valid (tick_valid),
    .tick       (tick)
  );

  qgps_legs u_legs (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .tick_valid (tick_valid),
    .tick       (tick),
    .take       (tick_take),
    .out_ch     (out_ch)
  );

  // legs of one tick follow each other without a gap
  `QGPS_ASSERT_NEXT(a_legs_back_to_back, out_ch.valid && out_ch.ready && !out_ch.last_leg, out_ch.valid)
  // the tick marker only ever sits on the rear right leg
  `QGPS_ASSERT_NOW(a_last_is_rear_right, out_ch.valid && out_ch.last_leg, out_ch.leg_number == LEG_LAST)
  // the input side only stalls with a tick already waiting
  `QGPS_ASSERT_NOW(a_stall_has_tick, !in_ch.ready, tick_valid)

endmodule

### verif/quadruped_gait_phase_sequencer_unit_tb.sv
// Self-checking testbench of the gait phase sequencer: directed table, random ticks, predictor.
module quadruped_gait_phase_sequencer_unit_tb;
  import qgps_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_OFF    = 150;
  localparam int DIR_ROWS    = 21;

  localparam logic [PHASE_W-1:0] PH_STANCE = 2'd0;
  localparam logic [PHASE_W-1:0] PH_SWING  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_PUSH   = 2'd2;
  localparam logic [PHASE_W-1:0] PH_LAND   = 2'd3;

  localparam logic [MODE_W-1:0] MODE_FAULT    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SHUTDOWN = 3'd5;

  typedef struct packed {
    logic [LEG_W-1:0]        leg;
    logic [PHASE_W-1:0]      phase;
    logic signed [CMD_W-1:0] yaw;
    logic signed [CMD_W-1:0] pitch;
    logic signed [CMD_W-1:0] knee;
    logic [MODE_W-1:0]       mode;
    logic [CNT_W-1:0]        cycles;
    logic                    last;
  } leg_word_t;

  // leg 0 values written out by hand for a directed tick
  typedef struct packed {
    logic                    known;
    logic [PHASE_W-1:0]      phase;
    logic signed [CMD_W-1:0] yaw;
    logic signed [CMD_W-1:0] pitch;
    logic signed [CMD_W-1:0] knee;
    logic [MODE_W-1:0]       mode;
    logic [CNT_W-1:0]        cycles;
  } tick_note_t;

  typedef struct packed {
    logic [PAT_W-1:0]        pattern;
    logic signed [CMD_W-1:0] lim_hi;
    logic signed [CMD_W-1:0] lim_lo;
    logic [DT_W-1:0]         dt;
    tick_note_t              note;
  } dir_row_t;

  localparam tick_note_t NO_NOTE = '0;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  qgps_in_if  in_ch ();
  qgps_out_if out_ch ();

  quadruped_gait_phase_sequencer_unit DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  // shadow of the registers and the gait state
  logic [PAT_W-1:0]        cfg_pattern;
  logic signed [CMD_W-1:0] cfg_hi;
  logic signed [CMD_W-1:0] cfg_lo;
  logic [WHEEL_W-1:0]      wheel_pos;
  logic [MODE_W-1:0]       gait_mode;
  logic [CNT_W-1:0]        gait_cycles;

  leg_word_t  leg_words_due[$];
  tick_note_t tick_notes[$];
  dir_row_t   dir_rows[DIR_ROWS];
  int         mismatch_count = 0;
  bit         idle_off = 1'b0;
  bit         hold_off_req = 1'b0;

  function automatic int draw_gap();
    if (idle_off || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  // byte lanes hold the wheel offset of legs 3..0
  function automatic logic [WHEEL_W-1:0] gait_lane_offset(input logic [PAT_W-1:0] pat,
                                                          input logic [LEG_W-1:0] leg);
    logic [31:0] lanes;
    case (pat)
      PAT_TROT:   lanes = 32'h0080_8000;
      PAT_BOUND:  lanes = 32'h8080_0000;
      PAT_GALLOP: lanes = 32'h80C0_4000;
      default:    lanes = 32'h0000_0000;
    endcase
    return lanes[8*leg +: 8];
  endfunction

  function automatic int phase_pose(input logic [PHASE_W-1:0] ph, input logic [JNT_W-1:0] jnt);
    int pose;
    pose = 0;
    if (jnt == JNT_HIP_PITCH) begin
      case (ph)
        PH_STANCE: pose = -2000;
        PH_SWING:  pose = 2500;
        PH_PUSH:   pose = -3500;
        default:   pose = 1000;
      endcase
    end else if (jnt == JNT_KNEE) begin
      case (ph)
        PH_STANCE: pose = -3000;
        PH_SWING:  pose = 4000;
        PH_PUSH:   pose = -1500;
        default:   pose = -1000;
      endcase
    end
    return pose;
  endfunction

  // right legs mirrored; upper clamp first so a crossed low limit wins
  function automatic logic signed [CMD_W-1:0] limited_pose(input logic [LEG_W-1:0] leg,
                                                           input logic [JNT_W-1:0] jnt,
                                                           input logic [PHASE_W-1:0] ph);
    int cmd;
    cmd = phase_pose(ph, jnt);
    if (leg[0]) cmd = -cmd;
    if (cmd > int'(cfg_hi)) cmd = int'(cfg_hi);
    if (cmd < int'(cfg_lo)) cmd = int'(cfg_lo);
    return CMD_W'(cmd);
  endfunction

  function automatic void advance_gait(input logic [DT_W-1:0] dt, input tick_note_t note);
    int unsigned        step;
    logic [WHEEL_W-1:0] pos;
    leg_word_t          w;
    if (cfg_pattern != PAT_STAND) begin
      step = (32'(dt) * 256) / CYCLE_PERIOD_MS;
      wheel_pos = WHEEL_W'(wheel_pos + step);
      // one bump per tick, however many times the wheel goes round
      if (step != 0 && 32'(wheel_pos) < step) gait_cycles = gait_cycles + 1;
    end else begin
      wheel_pos = '0;
    end
    case (gait_mode)
      MODE_BOOT:     gait_mode = MODE_CALIB;
      MODE_CALIB:    gait_mode = MODE_STAND;
      MODE_STAND:    if (cfg_pattern != PAT_STAND) gait_mode = MODE_LOCOMOTE;
      MODE_LOCOMOTE: if (cfg_pattern == PAT_STAND) gait_mode = MODE_STAND;
      MODE_FAULT, MODE_SHUTDOWN: ;
      default:       gait_mode = MODE_BOOT;
    endcase
    for (int l = 0; l < LEG_TOTAL; l++) begin
      pos = wheel_pos + gait_lane_offset(cfg_pattern, LEG_W'(l));
      w.leg    = LEG_W'(l);
      w.phase  = pos[7:6];
      w.yaw    = limited_pose(LEG_W'(l), JNT_HIP_YAW, pos[7:6]);
      w.pitch  = limited_pose(LEG_W'(l), JNT_HIP_PITCH, pos[7:6]);
      w.knee   = limited_pose(LEG_W'(l), JNT_KNEE, pos[7:6]);
      w.mode   = gait_mode;
      w.cycles = gait_cycles;
      w.last   = (l == LEG_TOTAL - 1);
      if (l == 0 && note.known) begin
        w.phase  = note.phase;
        w.yaw    = note.yaw;
        w.pitch  = note.pitch;
        w.knee   = note.knee;
        w.mode   = note.mode;
        w.cycles = note.cycles;
      end
      leg_words_due.push_back(w);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_leg_word(input leg_word_t got, input leg_word_t want);
    if (got.leg !== want.leg) report_mismatch("leg_number", 32'(got.leg), 32'(want.leg));
    if (got.phase !== want.phase) report_mismatch("leg_phase", 32'(got.phase), 32'(want.phase));
    if (got.yaw !== want.yaw) report_mismatch("hip_yaw_cmd", 32'(got.yaw), 32'(want.yaw));
    if (got.pitch !== want.pitch)
      report_mismatch("hip_pitch_cmd", 32'(got.pitch), 32'(want.pitch));
    if (got.knee !== want.knee) report_mismatch("knee_cmd", 32'(got.knee), 32'(want.knee));
    if (got.mode !== want.mode) report_mismatch("mode_now", 32'(got.mode), 32'(want.mode));
    if (got.cycles !== want.cycles) report_mismatch("cycles_done", got.cycles, want.cycles);
    if (got.last !== want.last) report_mismatch("last_leg", 32'(got.last), 32'(want.last));
  endtask

  // words out are checked before the tick of the same edge is predicted
  always @(posedge clk) begin : leg_word_check
    leg_word_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.leg    = out_ch.leg_number;
        got.phase  = out_ch.leg_phase;
        got.yaw    = out_ch.hip_yaw_cmd;
        got.pitch  = out_ch.hip_pitch_cmd;
        got.knee   = out_ch.knee_cmd;
        got.mode   = out_ch.mode_now;
        got.cycles = out_ch.cycles_done;
        got.last   = out_ch.last_leg;
        if (leg_words_due.size() == 0)
          report_mismatch("unexpected leg word", 32'(got.leg), 32'(0));
        else
          check_leg_word(got, leg_words_due.pop_front());
      end
      if (in_ch.valid && in_ch.ready)
        advance_gait(in_ch.dt_ms, tick_notes.pop_front());
    end
  end

  initial begin : leg_word_sink
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
      end
      stall = draw_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || psel || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("quadruped_gait_phase_sequencer_unit_tb NOT OK");
    $finish;
  end

  // setup and access cycles, then read the register back
  task automatic write_register(input logic [1:0] idx, input logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] mask;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_GAIT_PATTERN: cfg_pattern = data[PAT_W-1:0];
      REG_LIMIT_HIGH:   cfg_hi = data[CMD_W-1:0];
      REG_LIMIT_LOW:    cfg_lo = data[CMD_W-1:0];
      default: ;
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    mask = (idx == REG_GAIT_PATTERN) ? 32'h0000_0003 : 32'h0000_FFFF;
    if ((prdata & mask) !== (data & mask)) report_mismatch("register read", prdata, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    // idle cycle between transfers
    @(posedge clk);
  endtask

  task automatic send_tick(input logic [DT_W-1:0] dt, input tick_note_t note, input int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_notes.push_back(note);
    in_ch.valid <= 1'b1;
    in_ch.dt_ms <= dt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // step past the current edge first so the tick taken at this edge is already predicted
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (leg_words_due.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    dir_row_t                r;
    logic [PAT_W-1:0]        pat;
    logic signed [CMD_W-1:0] hi;
    logic signed [CMD_W-1:0] lo;
    logic [DT_W-1:0]         dt;
    int                      k;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.dt_ms <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    cfg_pattern = PAT_STAND;
    cfg_hi      = LIMIT_HIGH_RST;
    cfg_lo      = LIMIT_LOW_RST;
    wheel_pos   = '0;
    gait_mode   = MODE_BOOT;
    gait_cycles = '0;

    // boot and calib steps, stand clears the wheel
    dir_rows[0]  = '{PAT_STAND, 16'sh7FFF, 16'sh8000, 12'd0,
                     '{1'b1, PH_STANCE, 16'sd0, -16'sd2000, -16'sd3000, MODE_CALIB, 32'd0}};
    dir_rows[1]  = '{PAT_STAND, 16'sh7FFF, 16'sh8000, 12'd4095,
                     '{1'b1, PH_STANCE, 16'sd0, -16'sd2000, -16'sd3000, MODE_STAND, 32'd0}};
    // short tick: no wheel movement, stand moves on to locomote
    dir_rows[2]  = '{PAT_TROT, 16'sh7FFF, 16'sh8000, 12'd3,
                     '{1'b1, PH_STANCE, 16'sd0, -16'sd2000, -16'sd3000, MODE_LOCOMOTE, 32'd0}};
    dir_rows[3]  = '{PAT_TROT, 16'sh7FFF, 16'sh8000, 12'd4, NO_NOTE};
    dir_rows[4]  = '{PAT_TROT, 16'sh7FFF, 16'sh8000, 12'd200, NO_NOTE};
    dir_rows[5]  = '{PAT_TROT, 16'sh7FFF, 16'sh8000, 12'd600, NO_NOTE};
    // several turns in one tick
    dir_rows[6]  = '{PAT_TROT, 16'sh7FFF, 16'sh8000, 12'd4095, NO_NOTE};
    dir_rows[7]  = '{PAT_BOUND, 16'sh7FFF, 16'sh8000, 12'd100, NO_NOTE};
    dir_rows[8]  = '{PAT_GALLOP, 16'sh7FFF, 16'sh8000, 12'd250, NO_NOTE};
    // exactly one turn: wheel back where it was
    dir_rows[9]  = '{PAT_GALLOP, 16'sh7FFF, 16'sh8000, 12'd800, NO_NOTE};
    dir_rows[10] = '{PAT_GALLOP, 16'sh7FFF, 16'sh8000, 12'd3, NO_NOTE};
    dir_rows[11] = '{PAT_GALLOP, 16'sd1000, -16'sd1000, 12'd150, NO_NOTE};
    // crossed limits, low one wins; locomote drops back to stand
    dir_rows[12] = '{PAT_STAND, -16'sd500, 16'sd500, 12'd1000,
                     '{1'b1, PH_STANCE, 16'sd500, 16'sd500, 16'sd500, MODE_STAND, 32'd3}};
    dir_rows[13] = '{PAT_STAND, 16'sh8000, 16'sh8000, 12'd0,
                     '{1'b1, PH_STANCE, 16'sh8000, 16'sh8000, 16'sh8000, MODE_STAND, 32'd3}};
    dir_rows[14] = '{PAT_GALLOP, 16'sh7FFF, 16'sh7FFF, 12'd4095,
                     '{1'b1, PH_STANCE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, MODE_LOCOMOTE, 32'd4}};
    dir_rows[15] = '{PAT_TROT, 16'sh7FFF, 16'sh8000, 12'd1, NO_NOTE};
    dir_rows[16] = '{PAT_TROT, 16'sh7FFF, 16'sh8000, 12'd2048, NO_NOTE};
    dir_rows[17] = '{PAT_BOUND, 16'sh7FFF, 16'sh8000, 12'd4095, NO_NOTE};
    dir_rows[18] = '{PAT_GALLOP, 16'sd0, 16'sd0, 12'd77, NO_NOTE};
    dir_rows[19] = '{PAT_TROT, 16'sd2000, -16'sd2000, 12'd1234, NO_NOTE};
    dir_rows[20] = '{PAT_STAND, 16'sh7FFF, 16'sh8000, 12'd5, NO_NOTE};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.pattern != cfg_pattern || r.lim_hi != cfg_hi || r.lim_lo != cfg_lo) begin
        wait_idle();
        if (r.pattern != cfg_pattern) write_register(REG_GAIT_PATTERN, 32'(r.pattern));
        if (r.lim_hi != cfg_hi) write_register(REG_LIMIT_HIGH, {{16{r.lim_hi[15]}}, r.lim_hi});
        if (r.lim_lo != cfg_lo) write_register(REG_LIMIT_LOW, {{16{r.lim_lo[15]}}, r.lim_lo});
      end
      send_tick(r.dt, r.note, draw_gap());
    end

    for (int p = 0; p < 5; p++) begin
      wait_idle();
      pat = ($urandom_range(0, 3) == 0) ? PAT_STAND : PAT_W'($urandom_range(1, 3));
      case ($urandom_range(0, 3))
        0: begin
          hi = LIMIT_HIGH_RST;
          lo = LIMIT_LOW_RST;
        end
        1: begin
          k  = $urandom_range(0, 5000);
          hi = CMD_W'(k);
          lo = CMD_W'(-k);
        end
        2: begin
          hi = CMD_W'(-int'($urandom_range(0, 3000)));
          lo = CMD_W'($urandom_range(0, 3000));
        end
        default: begin
          hi = CMD_W'($urandom);
          lo = CMD_W'($urandom);
        end
      endcase
      write_register(REG_GAIT_PATTERN, 32'(pat));
      write_register(REG_LIMIT_HIGH, {{16{hi[15]}}, hi});
      write_register(REG_LIMIT_LOW, {{16{lo[15]}}, lo});
      idle_off = (p == 2);
      // receiver sits out a long stretch while ticks keep coming back to back
      if (p == 4) hold_off_req = 1'b1;
      for (int n = 0; n < 20; n++) begin
        case ($urandom_range(0, 3))
          0: dt = DT_W'($urandom_range(0, 7));
          1: dt = DT_W'($urandom_range(0, 4095));
          2: dt = DT_W'(800 * $urandom_range(1, 5) + $urandom_range(0, 6) - 3);
          default: dt = DT_W'($urandom);
        endcase
        send_tick(dt, NO_NOTE, (p == 4) ? 0 : draw_gap());
      end
    end
    idle_off = 1'b0;

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && leg_words_due.size() == 0)
      $display("quadruped_gait_phase_sequencer_unit_tb OK");
    else
      $display("quadruped_gait_phase_sequencer_unit_tb NOT OK");
    $finish;
  end

endmodule
